// ===== rtl/sprite_frame_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer assertion macros
// Short forms for concurrent assertions clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH

// Assertion that is switched off while reset is high.
`define SFS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sprite frame sequencer assertion failed");

// Assertion that is checked in every cycle, reset included.
`define SFS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sprite frame sequencer assertion failed");

`endif

// ===== rtl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Widths, request and register codes, and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

   localparam int STEP_DEPTH_DEF = 256;
   localparam int MAX_GRID_DEF   = 64;

   localparam int REQ_TYPE_W  = 2;
   localparam int ADDR_W      = 8;
   localparam int DUR_W       = 16;
   localparam int FRAME_IN_W  = 12;
   localparam int DELTA_W     = 16;
   localparam int FRAME_W     = 13;
   localparam int UV_LEFT_W   = 18;
   localparam int UV_TOP_W    = 19;
   localparam int ELAPSED_W   = 32;
   localparam int PASS_W      = 24;
   localparam int GRID_REG_W  = 7;
   localparam int CELL_W      = 13;
   localparam int COUNT_REG_W = 9;
   localparam int SPEED_W     = 2;
   localparam int INV_W       = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int MUL_A_W     = 16;
   localparam int MUL_B_W     = 20;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   localparam logic [CELL_W-1:0]  CELL_MAX       = CELL_W'(4096);
   localparam logic [MUL_B_W-1:0] ZERO_SPEED_INV = MUL_B_W'(999999);

   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_START = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_STOP  = 2'd3;

   localparam logic [SPEED_W-1:0] SPEED_FWD  = 2'd0;
   localparam logic [SPEED_W-1:0] SPEED_REV  = 2'd1;
   localparam logic [SPEED_W-1:0] SPEED_ZERO = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_COLS    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_ROWS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CELL_WIDTH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CELL_HEIGHT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_COUNT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SPEED_MODE    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_SPEED     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_REPEAT_ENABLE = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK_MUL,
      ST_TICK_CMP,
      ST_LOAD_FRAME,
      ST_HIDE_MUL,
      ST_HIDE_SET,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_LEFT_MUL,
      ST_TOP_MUL,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/sprite_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Plays a table of (duration, frame) steps and reports the shown frame and
// the texel origin of its cell in the sprite sheet.
// ----------------------------------------------------------------------------
// One word is taken at a time: req_ready is high only while the sequencer is
// idle. Every item runs the 13-step divider that splits the frame index
// into column and row; a tick while playing adds the threshold multiply, one
// that ends a step also a step table read, and a stop or the end of the
// sequence adds the multiply for the hidden frame. One multiplier serves the
// threshold, the hidden frame and both texel offsets. A new word may be
// accepted while the previous response still waits on rsp_ready. The step
// table comes up unwritten; reading an entry that was never loaded gives
// undefined data.
`default_nettype none

module sprite_frame_sequencer #(
   parameter int STEP_DEPTH = sfs_pkg::STEP_DEPTH_DEF,
   parameter int MAX_GRID   = sfs_pkg::MAX_GRID_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire [sfs_pkg::REQ_TYPE_W-1:0]        req_type,
   input  wire [sfs_pkg::ADDR_W-1:0]            req_entry_addr,
   input  wire [sfs_pkg::DUR_W-1:0]             req_entry_duration,
   input  wire [sfs_pkg::FRAME_IN_W-1:0]        req_entry_frame,
   input  wire [sfs_pkg::DELTA_W-1:0]           req_delta_time,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [sfs_pkg::FRAME_W-1:0]          rsp_frame_index,
   output logic [sfs_pkg::UV_LEFT_W-1:0]        rsp_uv_left,
   output logic [sfs_pkg::UV_TOP_W-1:0]         rsp_uv_top,
   output logic                                 rsp_running,
   output logic [sfs_pkg::PASS_W-1:0]           rsp_anim_time,
   input  wire                                  csr_write_en,
   input  wire [sfs_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire [sfs_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int PW      = $clog2(STEP_DEPTH);
   localparam int CW      = $clog2(STEP_DEPTH + 1);
   localparam int GW      = $clog2(MAX_GRID + 1);
   localparam int ENTRY_W = sfs_pkg::DUR_W + sfs_pkg::FRAME_IN_W;
   localparam int FW      = sfs_pkg::FRAME_W;
   localparam int EW      = sfs_pkg::ELAPSED_W;
   localparam int TW      = sfs_pkg::PASS_W;

   // Configuration registers.
   logic [sfs_pkg::GRID_REG_W-1:0]  image_cols_ff, image_rows_ff;
   logic [sfs_pkg::CELL_W-1:0]      cell_width_ff, cell_height_ff;
   logic [sfs_pkg::COUNT_REG_W-1:0] step_count_ff;
   logic [sfs_pkg::SPEED_W-1:0]     speed_mode_ff;
   logic [sfs_pkg::INV_W-1:0]       inv_speed_ff;
   logic                            repeat_en_ff;

   // Playback state.
   sfs_pkg::state_type state_ff, state_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic [EW-1:0]  elapsed_ff, elapsed_in;
   logic [TW-1:0]  pass_ff, pass_in;
   logic           play_ff, play_in;
   logic [FW-1:0]  shown_ff, shown_in;

   // Shared multiplier.
   logic                          mul_en;
   logic [sfs_pkg::MUL_A_W-1:0]   mul_a;
   logic [sfs_pkg::MUL_B_W-1:0]   mul_b;
   logic [sfs_pkg::PROD_W-1:0]    prod_ff, prod_in;

   logic [sfs_pkg::UV_LEFT_W-1:0] uv_left_ff, uv_left_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]                 rsp_frame_ff, rsp_frame_in;
   logic [sfs_pkg::UV_LEFT_W-1:0] rsp_left_ff, rsp_left_in;
   logic [sfs_pkg::UV_TOP_W-1:0]  rsp_top_ff, rsp_top_in;
   logic                          rsp_running_ff, rsp_running_in;
   logic [TW-1:0]                 rsp_time_ff, rsp_time_in;

   // Step table.
   logic                          ram_wr_en;
   logic                          ram_rd_en;
   logic [PW-1:0]                 ram_rd_addr;
   logic [ENTRY_W-1:0]            ram_rd_data;
   logic [sfs_pkg::DUR_W-1:0]     rd_dur;
   logic [sfs_pkg::FRAME_IN_W-1:0] rd_frame;

   // Divider.
   logic                          div_start;
   logic                          div_done;
   logic [FW-1:0]                 div_quot;
   logic [GW-1:0]                 div_rem;

   // Effective register values and step arithmetic.
   logic [GW-1:0]                 cols_eff, rows_eff;
   logic [CW-1:0]                 count_eff;
   logic [sfs_pkg::CELL_W-1:0]    cw_eff, ch_eff;
   logic                          zero_mode, reverse;
   logic                          thr_met;
   logic [CW-1:0]                 pos_inc;
   logic                          fwd_end, rev_end, at_end;
   logic [PW-1:0]                 next_pos;
   logic [TW:0]                   pass_sum;
   logic [TW-1:0]                 pass_sat;
   logic [EW:0]                   elapsed_sum;
   logic [EW-1:0]                 elapsed_sat;
   logic                          req_accept;

   // ------------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         image_cols_ff  <= sfs_pkg::GRID_REG_W'(1);
         image_rows_ff  <= sfs_pkg::GRID_REG_W'(1);
         cell_width_ff  <= sfs_pkg::CELL_W'(1);
         cell_height_ff <= sfs_pkg::CELL_W'(1);
         step_count_ff  <= sfs_pkg::COUNT_REG_W'(1);
         speed_mode_ff  <= sfs_pkg::SPEED_FWD;
         inv_speed_ff   <= sfs_pkg::INV_W'(256);
         repeat_en_ff   <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            sfs_pkg::REG_IMAGE_COLS: begin
               image_cols_ff <= csr_wdata[sfs_pkg::GRID_REG_W-1:0];
            end
            sfs_pkg::REG_IMAGE_ROWS: begin
               image_rows_ff <= csr_wdata[sfs_pkg::GRID_REG_W-1:0];
            end
            sfs_pkg::REG_CELL_WIDTH: begin
               cell_width_ff <= csr_wdata[sfs_pkg::CELL_W-1:0];
            end
            sfs_pkg::REG_CELL_HEIGHT: begin
               cell_height_ff <= csr_wdata[sfs_pkg::CELL_W-1:0];
            end
            sfs_pkg::REG_STEP_COUNT: begin
               step_count_ff <= csr_wdata[sfs_pkg::COUNT_REG_W-1:0];
            end
            sfs_pkg::REG_SPEED_MODE: begin
               speed_mode_ff <= csr_wdata[sfs_pkg::SPEED_W-1:0];
            end
            sfs_pkg::REG_INV_SPEED: begin
               inv_speed_ff <= csr_wdata[sfs_pkg::INV_W-1:0];
            end
            sfs_pkg::REG_REPEAT_ENABLE: begin
               repeat_en_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Out-of-range register values are pulled into their legal range.
   always_comb begin
      if (image_cols_ff == '0) begin
         cols_eff = GW'(1);
      end else if (int'(image_cols_ff) > MAX_GRID) begin
         cols_eff = GW'(MAX_GRID);
      end else begin
         cols_eff = GW'(image_cols_ff);
      end
      if (image_rows_ff == '0) begin
         rows_eff = GW'(1);
      end else if (int'(image_rows_ff) > MAX_GRID) begin
         rows_eff = GW'(MAX_GRID);
      end else begin
         rows_eff = GW'(image_rows_ff);
      end
      if (step_count_ff == '0) begin
         count_eff = CW'(1);
      end else if (int'(step_count_ff) > STEP_DEPTH) begin
         count_eff = CW'(STEP_DEPTH);
      end else begin
         count_eff = CW'(step_count_ff);
      end
   end

   assign cw_eff = (cell_width_ff > sfs_pkg::CELL_MAX) ? sfs_pkg::CELL_MAX : cell_width_ff;
   assign ch_eff = (cell_height_ff > sfs_pkg::CELL_MAX) ? sfs_pkg::CELL_MAX : cell_height_ff;

   assign zero_mode = speed_mode_ff >= sfs_pkg::SPEED_ZERO;
   assign reverse   = speed_mode_ff == sfs_pkg::SPEED_REV;

   // ------------------------------------------------------------------------
   // Step table
   // ------------------------------------------------------------------------
   assign req_accept = req_valid && req_ready;
   assign ram_wr_en  = req_accept && (req_type == sfs_pkg::REQ_WRITE)
                       && (int'(req_entry_addr) < STEP_DEPTH);

   sfs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STEP_DEPTH)
   ) u_step_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (PW'(req_entry_addr)),
      .wr_data ({req_entry_duration, req_entry_frame}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_dur   = ram_rd_data[ENTRY_W-1:sfs_pkg::FRAME_IN_W];
   assign rd_frame = ram_rd_data[sfs_pkg::FRAME_IN_W-1:0];

   // ------------------------------------------------------------------------
   // Divider for column and row of the shown frame
   // ------------------------------------------------------------------------
   sfs_div #(
      .DIVISOR_W (GW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (shown_ff),
      .divisor   (cols_eff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // ------------------------------------------------------------------------
   // Step arithmetic
   // ------------------------------------------------------------------------
   // In zero-speed mode the product is duration * 999999 without the 8.8
   // scale, so the elapsed time is compared unscaled.
   assign thr_met = zero_mode ? ({4'b0, elapsed_ff} >= prod_ff)
                              : ({elapsed_ff, 8'b0} >= {4'b0, prod_ff});

   assign pos_inc  = CW'(pos_ff) + CW'(1);
   assign fwd_end  = pos_inc >= count_eff;
   assign rev_end  = (pos_ff == '0) || (CW'(pos_ff) > count_eff);
   assign at_end   = reverse ? rev_end : fwd_end;

   always_comb begin
      if (reverse) begin
         next_pos = rev_end ? PW'(count_eff - CW'(1)) : pos_ff - PW'(1);
      end else begin
         next_pos = fwd_end ? '0 : PW'(pos_inc);
      end
   end

   assign pass_sum    = {1'b0, pass_ff} + (TW + 1)'(rd_dur);
   assign pass_sat    = pass_sum[TW] ? '1 : pass_sum[TW-1:0];
   assign elapsed_sum = {1'b0, elapsed_ff} + (EW + 1)'(req_delta_time);
   assign elapsed_sat = elapsed_sum[EW] ? '1 : elapsed_sum[EW-1:0];

   assign prod_in = mul_en ? (sfs_pkg::PROD_W'(mul_a) * sfs_pkg::PROD_W'(mul_b)) : prod_ff;

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      elapsed_in     = elapsed_ff;
      pass_in        = pass_ff;
      play_in        = play_ff;
      shown_in       = shown_ff;
      uv_left_in     = uv_left_ff;
      req_ready      = 1'b0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = pos_ff;
      mul_en         = 1'b0;
      mul_a          = '0;
      mul_b          = '0;
      div_start      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_frame_in   = rsp_frame_ff;
      rsp_left_in    = rsp_left_ff;
      rsp_top_in     = rsp_top_ff;
      rsp_running_in = rsp_running_ff;
      rsp_time_in    = rsp_time_ff;

      case (state_ff)
         sfs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_type)
                  sfs_pkg::REQ_WRITE: begin
                     state_in = sfs_pkg::ST_DIV_START;
                  end
                  sfs_pkg::REQ_TICK: begin
                     if (play_ff) begin
                        elapsed_in  = elapsed_sat;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pos_ff;
                        state_in    = sfs_pkg::ST_TICK_MUL;
                     end else begin
                        state_in = sfs_pkg::ST_DIV_START;
                     end
                  end
                  sfs_pkg::REQ_START: begin
                     pos_in     = '0;
                     elapsed_in = '0;
                     pass_in    = '0;
                     if (zero_mode) begin
                        play_in  = 1'b0;
                        shown_in = '0;
                        state_in = sfs_pkg::ST_DIV_START;
                     end else begin
                        play_in     = 1'b1;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        state_in    = sfs_pkg::ST_LOAD_FRAME;
                     end
                  end
                  default: begin
                     if (play_ff) begin
                        pos_in     = '0;
                        elapsed_in = '0;
                        play_in    = 1'b0;
                        state_in   = sfs_pkg::ST_HIDE_MUL;
                     end else begin
                        state_in = sfs_pkg::ST_DIV_START;
                     end
                  end
               endcase
            end
         end

         sfs_pkg::ST_TICK_MUL: begin
            mul_en   = 1'b1;
            mul_a    = rd_dur;
            mul_b    = zero_mode ? sfs_pkg::ZERO_SPEED_INV : sfs_pkg::MUL_B_W'(inv_speed_ff);
            state_in = sfs_pkg::ST_TICK_CMP;
         end

         sfs_pkg::ST_TICK_CMP: begin
            if (!thr_met) begin
               state_in = sfs_pkg::ST_DIV_START;
            end else begin
               pass_in    = pass_sat;
               elapsed_in = '0;
               if (at_end && !repeat_en_ff) begin
                  // End of the sequence: stop and hide, keeping the pass time.
                  pos_in   = '0;
                  play_in  = 1'b0;
                  state_in = sfs_pkg::ST_HIDE_MUL;
               end else begin
                  if (at_end) begin
                     pass_in = '0;
                  end
                  pos_in      = next_pos;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = next_pos;
                  state_in    = sfs_pkg::ST_LOAD_FRAME;
               end
            end
         end

         sfs_pkg::ST_LOAD_FRAME: begin
            shown_in = FW'(rd_frame);
            state_in = sfs_pkg::ST_DIV_START;
         end

         sfs_pkg::ST_HIDE_MUL: begin
            mul_en   = 1'b1;
            mul_a    = sfs_pkg::MUL_A_W'(cols_eff);
            mul_b    = sfs_pkg::MUL_B_W'(rows_eff);
            state_in = sfs_pkg::ST_HIDE_SET;
         end

         sfs_pkg::ST_HIDE_SET: begin
            shown_in = prod_ff[FW-1:0];
            state_in = sfs_pkg::ST_DIV_START;
         end

         sfs_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = sfs_pkg::ST_DIV_WAIT;
         end

         sfs_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = sfs_pkg::ST_LEFT_MUL;
            end
         end

         sfs_pkg::ST_LEFT_MUL: begin
            mul_en   = 1'b1;
            mul_a    = sfs_pkg::MUL_A_W'(div_rem);
            mul_b    = sfs_pkg::MUL_B_W'(cw_eff);
            state_in = sfs_pkg::ST_TOP_MUL;
         end

         sfs_pkg::ST_TOP_MUL: begin
            uv_left_in = prod_ff[sfs_pkg::UV_LEFT_W-1:0];
            mul_en     = 1'b1;
            mul_a      = sfs_pkg::MUL_A_W'(div_quot);
            mul_b      = sfs_pkg::MUL_B_W'(ch_eff);
            state_in   = sfs_pkg::ST_RESP;
         end

         sfs_pkg::ST_RESP: begin
            // Wait here until the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_frame_in   = shown_ff;
               rsp_left_in    = uv_left_ff;
               rsp_top_in     = prod_ff[sfs_pkg::UV_TOP_W-1:0];
               rsp_running_in = play_ff;
               rsp_time_in    = pass_ff;
               state_in       = sfs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sfs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfs_pkg::ST_IDLE;
         pos_ff       <= '0;
         elapsed_ff   <= '0;
         pass_ff      <= '0;
         play_ff      <= 1'b0;
         shown_ff     <= FW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         elapsed_ff   <= elapsed_in;
         pass_ff      <= pass_in;
         play_ff      <= play_in;
         shown_ff     <= shown_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff        <= prod_in;
      uv_left_ff     <= uv_left_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_left_ff    <= rsp_left_in;
      rsp_top_ff     <= rsp_top_in;
      rsp_running_ff <= rsp_running_in;
      rsp_time_ff    <= rsp_time_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_index = rsp_frame_ff;
   assign rsp_uv_left     = rsp_left_ff;
   assign rsp_uv_top      = rsp_top_ff;
   assign rsp_running     = rsp_running_ff;
   assign rsp_anim_time   = rsp_time_ff;

endmodule

`default_nettype wire

// ===== rtl/sfs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sfs_div.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer divider
// Restoring divider that splits a frame index into row and column, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_div #(
   parameter int DIVISOR_W = 7
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire [sfs_pkg::FRAME_W-1:0]       dividend,
   input  wire [DIVISOR_W-1:0]              divisor,
   output logic                             done,
   output logic [sfs_pkg::FRAME_W-1:0]      quotient,
   output logic [DIVISOR_W-1:0]             remainder
);

   localparam int QW      = sfs_pkg::FRAME_W;
   localparam int COUNT_W = $clog2(QW + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]      quot_ff, quot_in;

   logic [DIVISOR_W:0] shifted;
   logic [DIVISOR_W:0] diff;
   logic               ge;

   assign shifted = {rem_ff, quot_ff[QW-1]};
   assign ge      = shifted >= {1'b0, divisor};
   assign diff    = shifted - {1'b0, divisor};

   // The divisor must hold for the whole run; it comes from configuration.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = COUNT_W'(QW);
         rem_in   = '0;
         quot_in  = dividend;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quot_in  = {quot_ff[QW-2:0], ge};
         count_in = count_ff - COUNT_W'(1);
         if (count_ff == COUNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/sfs_checker.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer checker
// Port-level assertions on the sequencer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sprite_frame_sequencer_assert.svh"

module sfs_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_ready,
   input wire                              rsp_valid,
   input wire                              rsp_ready,
   input wire [sfs_pkg::FRAME_W-1:0]       rsp_frame_index,
   input wire [sfs_pkg::UV_LEFT_W-1:0]     rsp_uv_left,
   input wire [sfs_pkg::UV_TOP_W-1:0]      rsp_uv_top,
   input wire [sfs_pkg::PASS_W-1:0]        rsp_anim_time
);

   // The sequencer works on one word at a time.
   `SFS_ASSERT(busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready)

   // A stalled response keeps its contents.
   `SFS_ASSERT(rsp_held, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_frame_index) && $stable(rsp_uv_left) && $stable(rsp_uv_top) && $stable(rsp_anim_time)))

   // Coming out of reset the block is idle with nothing to deliver.
   `SFS_ASSERT_ALWAYS(reset_idle, clock, $past(reset) |-> (req_ready && !rsp_valid))

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_frame_index (rsp_frame_index),
   .rsp_uv_left     (rsp_uv_left),
   .rsp_uv_top      (rsp_uv_top),
   .rsp_anim_time   (rsp_anim_time)
);

`default_nettype wire
